>>> src/linear_probe_hash_lookup_defines.svh
// Assertion macros for the hash table lookup block.
`ifndef LINEAR_PROBE_HASH_LOOKUP_DEFINES_SVH
`define LINEAR_PROBE_HASH_LOOKUP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPHL_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lphl: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LPHL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lphl: next-cycle check failed");

`endif

>>> src/lphl_pkg.sv
// Shared constants and types for the hash table lookup block.
package lphl_pkg;

  localparam int unsigned SLOTS   = 1024;
  localparam int unsigned IDX_W   = $clog2(SLOTS);
  localparam int unsigned CAP_W   = IDX_W + 1;
  localparam int unsigned KEY_W   = 31;
  localparam int unsigned ST_W    = 2;
  localparam int unsigned ENTRY_W = ST_W + KEY_W;
  localparam int unsigned BIT_W   = $clog2(KEY_W);

  typedef logic [ST_W-1:0] status_t;

  localparam status_t ST_EMPTY    = 2'd0;
  localparam status_t ST_DELETED  = 2'd1;
  localparam status_t ST_OCCUPIED = 2'd2;

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(SLOTS);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_DIV   = 5'b00100,
    S_PROBE = 5'b01000,
    S_FIN   = 5'b10000
  } state_e;

endpackage

>>> src/linear_probe_hash_lookup.sv
// Top level: open-addressing hash table with linear probing, held in one memory.
//
//   Channel   Direction  Handshake                    Payload
//   input     in         in_valid_i / in_stall_o      mode, slot_index, slot_status,
//                                                     slot_key, lookup_key
//   result    out        out_valid_o / out_stall_i    found, found_key, probe_count
//   config    in         cfg_wr_en_i                  cfg_wr_data_i (table capacity)
//
// A write item writes the slot as the item is accepted.
// A lookup first reduces the key modulo capacity bit-serially, then makes
// one probe per cycle through the table memory.
// After reset a clearing pass empties every slot; no item is accepted
// meanwhile. One item is in work at a time; a finished result waits
// in the output register while the next item is taken, and holds under stall.
module linear_probe_hash_lookup (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_wr_en_i,
  input  logic [lphl_pkg::CAP_W-1:0]  cfg_wr_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        mode_i,
  input  logic [lphl_pkg::IDX_W-1:0]  slot_index_i,
  input  logic [lphl_pkg::ST_W-1:0]   slot_status_i,
  input  logic [lphl_pkg::KEY_W-1:0]  slot_key_i,
  input  logic [lphl_pkg::KEY_W-1:0]  lookup_key_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        found_o,
  output logic [lphl_pkg::KEY_W-1:0]  found_key_o,
  output logic [lphl_pkg::CAP_W-1:0]  probe_count_o
);

  `include "linear_probe_hash_lookup_defines.svh"

  lphl_pkg::state_e state_q, state_d;

  logic [lphl_pkg::CAP_W-1:0]   cap_q;
  logic [lphl_pkg::CAP_W-1:0]   cap_use;
  logic [lphl_pkg::IDX_W-1:0]   clr_q, clr_d;
  logic [lphl_pkg::IDX_W-1:0]   pos_q, pos_d;
  logic [lphl_pkg::BIT_W-1:0]   cnt_q, cnt_d;
  logic [lphl_pkg::CAP_W-1:0]   probes_q, probes_d;
  logic [lphl_pkg::CAP_W-1:0]   probes_inc;
  logic [lphl_pkg::CAP_W-1:0]   pos_inc;
  logic                         res_found_q, res_found_d;
  logic [lphl_pkg::KEY_W-1:0]   key_q, key_d;
  logic [lphl_pkg::CAP_W-1:0]   div_shift;
  logic [lphl_pkg::CAP_W-1:0]   div_rem;

  logic [lphl_pkg::ENTRY_W-1:0] mem_q [lphl_pkg::SLOTS];
  logic [lphl_pkg::ENTRY_W-1:0] rdata_q;
  logic                         mem_we;
  logic [lphl_pkg::IDX_W-1:0]   mem_wa;
  logic [lphl_pkg::ENTRY_W-1:0] mem_wd;
  lphl_pkg::status_t            rd_status;
  logic [lphl_pkg::KEY_W-1:0]   rd_key;

  logic                         out_load;
  logic                         out_valid_q;
  logic                         found_q;
  logic [lphl_pkg::KEY_W-1:0]   found_key_q;
  logic [lphl_pkg::CAP_W-1:0]   probe_count_q;

  // Capacity register, saturated to 1..SLOTS for use.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lphl_pkg::CAP_RESET;
    end else if (cfg_wr_en_i) begin
      cap_q <= cfg_wr_data_i;
    end
  end

  always_comb begin
    if (cap_q == '0) begin
      cap_use = lphl_pkg::CAP_W'(1);
    end else if (cap_q > lphl_pkg::CAP_W'(lphl_pkg::SLOTS)) begin
      cap_use = lphl_pkg::CAP_W'(lphl_pkg::SLOTS);
    end else begin
      cap_use = cap_q;
    end
  end

  assign rd_status  = rdata_q[lphl_pkg::ENTRY_W-1 -: lphl_pkg::ST_W];
  assign rd_key     = rdata_q[lphl_pkg::KEY_W-1:0];
  assign probes_inc = probes_q + lphl_pkg::CAP_W'(1);
  assign pos_inc    = {1'b0, pos_q} + lphl_pkg::CAP_W'(1);

  // One restoring step of key modulo capacity; the remainder stays below capacity.
  assign div_shift = {pos_q, key_q[cnt_q]};
  assign div_rem   = (div_shift >= cap_use) ? (div_shift - cap_use) : div_shift;

  assign in_stall_o = (state_q != lphl_pkg::S_IDLE);
  assign out_load   = (state_q == lphl_pkg::S_FIN) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    probes_d    = probes_q;
    res_found_d = res_found_q;
    key_d       = key_q;
    mem_we      = 1'b0;
    mem_wa      = clr_q;
    mem_wd      = '0;
    case (state_q)
      lphl_pkg::S_CLEAR: begin
        mem_we = 1'b1;
        clr_d  = clr_q + lphl_pkg::IDX_W'(1);
        if (clr_q == lphl_pkg::IDX_W'(lphl_pkg::SLOTS - 1)) begin
          state_d = lphl_pkg::S_IDLE;
        end
      end
      lphl_pkg::S_IDLE: begin
        if (in_valid_i) begin
          probes_d    = '0;
          res_found_d = 1'b0;
          if (mode_i == lphl_pkg::MODE_WRITE) begin
            mem_we  = 1'b1;
            mem_wa  = slot_index_i;
            mem_wd  = {slot_status_i, slot_key_i};
            state_d = lphl_pkg::S_FIN;
          end else begin
            key_d   = lookup_key_i;
            pos_d   = '0;
            cnt_d   = lphl_pkg::BIT_W'(lphl_pkg::KEY_W - 1);
            state_d = lphl_pkg::S_DIV;
          end
        end
      end
      lphl_pkg::S_DIV: begin
        pos_d = div_rem[lphl_pkg::IDX_W-1:0];
        cnt_d = cnt_q - lphl_pkg::BIT_W'(1);
        if (cnt_q == '0) begin
          state_d = lphl_pkg::S_PROBE;
        end
      end
      lphl_pkg::S_PROBE: begin
        // The memory output holds the slot at pos_q; the next slot is read
        // ahead, which is harmless when the search stops here.
        probes_d = probes_inc;
        if (rd_status == lphl_pkg::ST_EMPTY) begin
          state_d = lphl_pkg::S_FIN;
        end else if (rd_status == lphl_pkg::ST_OCCUPIED && rd_key == key_q) begin
          res_found_d = 1'b1;
          state_d     = lphl_pkg::S_FIN;
        end else if (probes_inc == cap_use) begin
          state_d = lphl_pkg::S_FIN;
        end else if (pos_inc == cap_use) begin
          pos_d = '0;
        end else begin
          pos_d = pos_inc[lphl_pkg::IDX_W-1:0];
        end
      end
      lphl_pkg::S_FIN: begin
        if (out_load) begin
          state_d = lphl_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = lphl_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lphl_pkg::S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q       <= pos_d;
    cnt_q       <= cnt_d;
    probes_q    <= probes_d;
    res_found_q <= res_found_d;
    key_q       <= key_d;
    if (out_load) begin
      found_q       <= res_found_q;
      found_key_q   <= res_found_q ? key_q : '0;
      probe_count_q <= probes_q;
    end
  end

  // Table memory: one write port, one read port at the next probe position.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rdata_q <= mem_q[pos_d];
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign found_key_o   = found_key_q;
  assign probe_count_o = probe_count_q;

  `LPHL_ASSERT_IMPL(a_found_probed, out_valid_o && found_o, probe_count_o != '0)
  `LPHL_ASSERT_IMPL(a_probe_bounds, state_q == lphl_pkg::S_PROBE,
                    {1'b0, pos_q} < cap_use && probes_q < cap_use)
  `LPHL_ASSERT_NEXT(a_div_to_probe, state_q == lphl_pkg::S_DIV && cnt_q == '0,
                    state_q == lphl_pkg::S_PROBE && {1'b0, pos_q} < cap_use)

endmodule

>>> bench/tb_top.sv
// Self-checking bench for the linear-probing hash table lookup block.

typedef struct packed {
  logic                       found;
  logic [lphl_pkg::KEY_W-1:0] key;
  logic [lphl_pkg::CAP_W-1:0] probes;
} probe_outcome_t;

class hash_table_mirror;
  lphl_pkg::status_t          slot_status [lphl_pkg::SLOTS];
  logic [lphl_pkg::KEY_W-1:0] slot_key [lphl_pkg::SLOTS];
  logic [lphl_pkg::CAP_W-1:0] cap_reg;
  probe_outcome_t             awaited_outcomes [$];
  int unsigned                mismatches;

  function new();
    foreach (slot_status[i]) begin
      slot_status[i] = lphl_pkg::ST_EMPTY;
      slot_key[i] = '0;
    end
    cap_reg = lphl_pkg::CAP_RESET;
    mismatches = 0;
  endfunction

  // The register saturates to the range 1 to SLOTS.
  function int unsigned capacity_in_use();
    if (cap_reg == 0) return 1;
    if (cap_reg > lphl_pkg::SLOTS) return lphl_pkg::SLOTS;
    return cap_reg;
  endfunction

  function int unsigned pending();
    return awaited_outcomes.size();
  endfunction

  function void note_item(logic mode, logic [lphl_pkg::IDX_W-1:0] idx, lphl_pkg::status_t st,
                          logic [lphl_pkg::KEY_W-1:0] skey,
                          logic [lphl_pkg::KEY_W-1:0] lkey);
    probe_outcome_t outcome;
    int unsigned    cap;
    int unsigned    pos;
    int unsigned    probes;
    bit             done;
    outcome = '0;
    if (mode == lphl_pkg::MODE_WRITE) begin
      slot_status[idx] = st;
      slot_key[idx] = skey;
    end else begin
      cap = capacity_in_use();
      pos = lkey % cap;
      probes = 0;
      done = 1'b0;
      // Deleted slots and status three are stepped over; an empty slot ends the search.
      while (!done && probes < cap) begin
        probes++;
        if (slot_status[pos] == lphl_pkg::ST_EMPTY) begin
          done = 1'b1;
        end else if (slot_status[pos] == lphl_pkg::ST_OCCUPIED && slot_key[pos] == lkey) begin
          outcome.found = 1'b1;
          outcome.key = lkey;
          done = 1'b1;
        end else begin
          pos = (pos + 1 == cap) ? 0 : pos + 1;
        end
      end
      outcome.probes = probes[lphl_pkg::CAP_W-1:0];
    end
    awaited_outcomes.push_back(outcome);
  endfunction

  function void check_outcome(logic found, logic [lphl_pkg::KEY_W-1:0] key,
                              logic [lphl_pkg::CAP_W-1:0] probes, realtime now);
    probe_outcome_t want;
    if (awaited_outcomes.size() == 0) begin
      $display("%0.1f ns: result with none awaited: found=%0d key=%0d probes=%0d",
               now, found, key, probes);
      mismatches++;
      return;
    end
    want = awaited_outcomes.pop_front();
    if (found !== want.found) begin
      $display("%0.1f ns: found expected %0d, got %0d", now, want.found, found);
      mismatches++;
    end
    if (key !== want.key) begin
      $display("%0.1f ns: found_key expected %0d, got %0d", now, want.key, key);
      mismatches++;
    end
    if (probes !== want.probes) begin
      $display("%0.1f ns: probe_count expected %0d, got %0d", now, want.probes, probes);
      mismatches++;
    end
  endfunction
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [lphl_pkg::KEY_W-1:0] KEY_MAX = '1;
  localparam lphl_pkg::status_t ST_RESERVED = 2'd3;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_wr_en_i = 1'b0;
  logic [lphl_pkg::CAP_W-1:0] cfg_wr_data_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic                       mode_i = lphl_pkg::MODE_WRITE;
  logic [lphl_pkg::IDX_W-1:0] slot_index_i = '0;
  logic [lphl_pkg::ST_W-1:0]  slot_status_i = lphl_pkg::ST_EMPTY;
  logic [lphl_pkg::KEY_W-1:0] slot_key_i = '0;
  logic [lphl_pkg::KEY_W-1:0] lookup_key_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic                       found_o;
  logic [lphl_pkg::KEY_W-1:0] found_key_o;
  logic [lphl_pkg::CAP_W-1:0] probe_count_o;

  bit                         calm = 1'b0;
  logic [lphl_pkg::KEY_W-1:0] recent_keys [$];
  hash_table_mirror           mirror = new();

  linear_probe_hash_lookup dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Entered and left at a falling edge.
  task automatic send_item(logic m, logic [lphl_pkg::IDX_W-1:0] idx, lphl_pkg::status_t st,
                           logic [lphl_pkg::KEY_W-1:0] skey,
                           logic [lphl_pkg::KEY_W-1:0] lkey);
    while (!calm && $urandom_range(0, 99) < 18) @(negedge clk_i);
    in_valid_i = 1'b1;
    mode_i = m;
    slot_index_i = idx;
    slot_status_i = st;
    slot_key_i = skey;
    lookup_key_i = lkey;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    mirror.note_item(m, idx, st, skey, lkey);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic write_slot(logic [lphl_pkg::IDX_W-1:0] idx, lphl_pkg::status_t st,
                            logic [lphl_pkg::KEY_W-1:0] key);
    send_item(lphl_pkg::MODE_WRITE, idx, st, key, lphl_pkg::KEY_W'($urandom()));
  endtask

  task automatic look_up(logic [lphl_pkg::KEY_W-1:0] key);
    send_item(lphl_pkg::MODE_LOOKUP, lphl_pkg::IDX_W'($urandom()),
              lphl_pkg::status_t'($urandom()), lphl_pkg::KEY_W'($urandom()), key);
  endtask

  task automatic await_all_results();
    while (mirror.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // The capacity is only changed once the block has gone quiet.
  task automatic reconfigure(logic [lphl_pkg::CAP_W-1:0] value);
    await_all_results();
    cfg_wr_en_i = 1'b1;
    cfg_wr_data_i = value;
    @(negedge clk_i);
    cfg_wr_en_i = 1'b0;
    mirror.cap_reg = value;
  endtask

  function automatic lphl_pkg::status_t pick_status(bit non_empty);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!non_empty && roll < 15) return lphl_pkg::ST_EMPTY;
    if (roll < 30) return lphl_pkg::ST_DELETED;
    if (roll < 42) return ST_RESERVED;
    return lphl_pkg::ST_OCCUPIED;
  endfunction

  // Most keys are built to hash into a small cluster so that chains of collisions form,
  // and most lookups ask for keys written a little earlier.
  task automatic random_phase(logic [lphl_pkg::CAP_W-1:0] setting, int unsigned n_items);
    int unsigned                cap;
    int unsigned                cluster;
    int unsigned                home;
    int unsigned                roll;
    logic [63:0]                wide;
    logic [lphl_pkg::KEY_W-1:0] key;
    reconfigure(setting);
    cap = mirror.capacity_in_use();
    cluster = $urandom_range(0, cap - 1);
    recent_keys.delete();
    repeat (n_items) begin
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        home = (roll < 30) ? (cluster + $urandom_range(0, 15)) % cap
                           : $urandom_range(0, cap - 1);
        wide = 64'($urandom_range(0, 32'h7FFF_FFFF / cap)) * cap + home;
        key = wide[lphl_pkg::KEY_W-1:0];
        recent_keys.push_back(key);
        if (recent_keys.size() > 24) void'(recent_keys.pop_front());
        if (roll < 5) begin
          write_slot(lphl_pkg::IDX_W'($urandom_range(0, lphl_pkg::SLOTS - 1)),
                     pick_status(1'b0), key);
        end else begin
          write_slot(lphl_pkg::IDX_W'((home + $urandom_range(0, 3)) % cap),
                     pick_status(1'b0), key);
        end
      end else if (roll < 90 && recent_keys.size() != 0) begin
        look_up(recent_keys[$urandom_range(0, recent_keys.size() - 1)]);
      end else begin
        look_up(lphl_pkg::KEY_W'($urandom()));
      end
    end
  endtask

  // Every slot in use ends up non-empty, so a missing key walks the whole table.
  task automatic full_table_phase();
    int unsigned i;
    reconfigure(lphl_pkg::CAP_W'(512));
    for (i = 0; i < 512; i++) begin
      write_slot(lphl_pkg::IDX_W'(i), pick_status(1'b1), lphl_pkg::KEY_W'($urandom()));
      if (i % 64 == 63) look_up(lphl_pkg::KEY_W'($urandom()));
    end
    repeat (10) look_up(lphl_pkg::KEY_W'($urandom()));
    repeat (10) look_up(mirror.slot_key[$urandom_range(0, 511)]);
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && !out_stall_i) begin
        mirror.check_outcome(found_o, found_key_o, probe_count_o, $realtime);
      end
      @(negedge clk_i);
      out_stall_i = !calm && ($urandom_range(0, 99) < 18);
    end
  end

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Capacity at its reset value.
    look_up('0);
    look_up(KEY_MAX);
    write_slot('0, lphl_pkg::ST_OCCUPIED, '0);
    look_up('0);
    write_slot(lphl_pkg::IDX_W'(lphl_pkg::SLOTS - 1), lphl_pkg::ST_OCCUPIED, KEY_MAX);
    look_up(KEY_MAX);
    write_slot(5, lphl_pkg::ST_DELETED, 5);
    write_slot(6, ST_RESERVED, 6);
    write_slot(7, lphl_pkg::ST_OCCUPIED, 5);
    look_up(5);
    look_up(6);
    // Hashes to the last slot and wraps round to the start.
    look_up(2047);
    write_slot(1, lphl_pkg::ST_OCCUPIED, 2047);
    look_up(2047);
    write_slot(300, lphl_pkg::ST_EMPTY, 300);
    look_up(300);

    // A zero register acts as a single slot, which is then a full table.
    reconfigure('0);
    look_up(12345);
    look_up('0);

    reconfigure(3);
    write_slot(2, lphl_pkg::ST_DELETED, 2);
    look_up(5);
    write_slot(900, lphl_pkg::ST_OCCUPIED, 900);
    look_up(900);

    random_phase(11'd2047, 120);
    random_phase(11'd1, 40);
    random_phase(11'd2, 60);
    calm = 1'b1;
    random_phase(11'd7, 90);
    calm = 1'b0;
    random_phase(11'd64, 130);
    random_phase(11'd1000, 100);
    random_phase(11'd1025, 80);
    random_phase(11'd33, 100);
    random_phase(11'd0, 25);
    full_table_phase();

    await_all_results();
    repeat (60) @(posedge clk_i);
    if (mirror.mismatches == 0 && mirror.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("Timed out waiting for the block");
    $display("Some tests failed");
    $finish;
  end
endmodule

>>> filelist.f
+incdir+src
src/lphl_pkg.sv
src/linear_probe_hash_lookup.sv
bench/tb_top.sv
